// File: rtl/dtbl_pkg.sv
`default_nettype none
package dtbl_pkg;

  localparam int unsigned TableEntries = 64;
  localparam int unsigned FracBits     = 16;
  localparam int unsigned IdxW         = $clog2(TableEntries);
  localparam int unsigned KeyW         = 33;
  localparam int unsigned TickW        = 48;
  localparam int unsigned RateW        = 24;
  localparam int unsigned BurstW       = 16;
  localparam int unsigned TokW         = BurstW + FracBits;
  localparam int unsigned ElW          = 40;
  localparam int unsigned ElHalfW      = ElW / 2;
  localparam int unsigned ProdW        = ElHalfW + RateW;
  localparam int unsigned SumW         = 65;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned CfgDataW     = 24;

  localparam logic [CfgIdxW-1:0] CfgAddrRate  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgAddrBurst = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgSessRate  = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSessBurst = 2'd3;

  localparam logic [ElW-1:0] ElMax = {ElW{1'b1}};

  typedef struct packed {
    logic             req_type;
    logic [31:0]      session_id;
    logic [31:0]      ip_addr;
    logic [TickW-1:0] now_ticks;
  } req_t;

  typedef struct packed {
    logic allowed;
    logic table_full;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture input word
    logic sess;        // work on the session key
    logic scan_start;
    logic take_hit;    // slot := matched entry
    logic alloc;       // slot := lowest free entry, start full
    logic ld_cur;      // latch stored tokens / tick
    logic el_en;
    logic mul_en;
    logic add_en;
    logic upd_en;      // refill, consume, write back
    logic rm_clear;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic hit;
    logic has_free;
    logic grant;
  } sts_t;

endpackage
`default_nettype wire

// File: rtl/dtbl_ctrl.sv
`default_nettype none
module dtbl_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          req_type_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output dtbl_pkg::rsp_t     out_data_o,
  output dtbl_pkg::cmd_t     cmd_o,
  input  wire dtbl_pkg::sts_t sts_i
);

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StScan = 4'd1;
  localparam logic [3:0] StLook = 4'd2;
  localparam logic [3:0] StRd   = 4'd3;
  localparam logic [3:0] StLdc  = 4'd4;
  localparam logic [3:0] StEl   = 4'd5;
  localparam logic [3:0] StMul  = 4'd6;
  localparam logic [3:0] StAdd  = 4'd7;
  localparam logic [3:0] StUpd  = 4'd8;
  localparam logic [3:0] StChk  = 4'd9;
  localparam logic [3:0] StOut  = 4'd10;

  logic [3:0]     state_q, state_d;
  logic           rm_q, rm_d;
  logic           sess_q, sess_d;
  dtbl_pkg::rsp_t res_q, res_d;
  logic           ovld_q, ovld_d;
  dtbl_pkg::rsp_t odata_q, odata_d;
  logic           accept;

  assign in_ready_o  = (state_q == StIdle);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = ovld_q;
  assign out_data_o  = odata_q;

  always_comb begin
    state_d = state_q;
    rm_d    = rm_q;
    sess_d  = sess_q;
    res_d   = res_q;
    ovld_d  = ovld_q && !out_ready_i;
    odata_d = odata_q;
    cmd_o   = '0;
    cmd_o.sess = sess_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          rm_d   = req_type_i;
          sess_d = req_type_i;
          cmd_o.load       = 1'b1;
          cmd_o.scan_start = 1'b1;
          cmd_o.sess       = req_type_i;
          state_d = StScan;
        end
      end
      StScan: begin
        if (sts_i.scan_done) begin
          state_d = StLook;
        end
      end
      StLook: begin
        priority if (rm_q) begin
          cmd_o.rm_clear = 1'b1;
          res_d   = '0;
          state_d = StOut;
        end else if (sts_i.hit) begin
          cmd_o.take_hit = 1'b1;
          state_d = StRd;
        end else if (sts_i.has_free) begin
          cmd_o.alloc = 1'b1;
          state_d = StEl;
        end else begin
          res_d.allowed    = 1'b0;
          res_d.table_full = 1'b1;
          state_d = StOut;
        end
      end
      StRd:  state_d = StLdc;
      StLdc: begin
        cmd_o.ld_cur = 1'b1;
        state_d = StEl;
      end
      StEl: begin
        cmd_o.el_en = 1'b1;
        state_d = StMul;
      end
      StMul: begin
        cmd_o.mul_en = 1'b1;
        state_d = StAdd;
      end
      StAdd: begin
        cmd_o.add_en = 1'b1;
        state_d = StUpd;
      end
      StUpd: begin
        cmd_o.upd_en = 1'b1;
        state_d = StChk;
      end
      StChk: begin
        if (!sess_q && sts_i.grant) begin
          // address token taken, now test the session bucket
          sess_d = 1'b1;
          cmd_o.sess       = 1'b1;
          cmd_o.scan_start = 1'b1;
          state_d = StScan;
        end else begin
          res_d.allowed    = sess_q && sts_i.grant;
          res_d.table_full = 1'b0;
          state_d = StOut;
        end
      end
      StOut: begin
        if (!ovld_q || out_ready_i) begin
          ovld_d  = 1'b1;
          odata_d = res_q;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      rm_q    <= 1'b0;
      sess_q  <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      rm_q    <= rm_d;
      sess_q  <= sess_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q   <= res_d;
    odata_q <= odata_d;
  end

endmodule
`default_nettype wire

// File: rtl/dtbl_dp.sv
`default_nettype none
module dtbl_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire dtbl_pkg::req_t                in_data_i,
  input  wire logic                          cfg_valid_i,
  input  wire logic [dtbl_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [dtbl_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire dtbl_pkg::cmd_t                cmd_i,
  output dtbl_pkg::sts_t                     sts_o
);

  localparam logic [dtbl_pkg::IdxW-1:0] LastIdx =
    dtbl_pkg::IdxW'(dtbl_pkg::TableEntries - 1);
  localparam logic [dtbl_pkg::TokW-1:0] OneTok =
    dtbl_pkg::TokW'(1) << dtbl_pkg::FracBits;

  // config
  logic [dtbl_pkg::RateW-1:0]  addr_rate_q, sess_rate_q;
  logic [dtbl_pkg::BurstW-1:0] addr_burst_q, sess_burst_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_rate_q  <= '0;
      addr_burst_q <= '0;
      sess_rate_q  <= '0;
      sess_burst_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        dtbl_pkg::CfgAddrRate:  addr_rate_q  <= cfg_data_i;
        dtbl_pkg::CfgAddrBurst: addr_burst_q <= cfg_data_i[dtbl_pkg::BurstW-1:0];
        dtbl_pkg::CfgSessRate:  sess_rate_q  <= cfg_data_i;
        dtbl_pkg::CfgSessBurst: sess_burst_q <= cfg_data_i[dtbl_pkg::BurstW-1:0];
        default: ;
      endcase
    end
  end

  dtbl_pkg::req_t req_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= in_data_i;
  end

  logic [dtbl_pkg::KeyW-1:0]   key_cur;
  logic [dtbl_pkg::RateW-1:0]  rate;
  logic [dtbl_pkg::TokW-1:0]   cap;
  assign key_cur = cmd_i.sess ? {1'b1, req_q.session_id} : {1'b0, req_q.ip_addr};
  assign rate    = cmd_i.sess ? sess_rate_q : addr_rate_q;
  assign cap     = {(cmd_i.sess ? sess_burst_q : addr_burst_q),
                    {dtbl_pkg::FracBits{1'b0}}};

  // key scan: one entry per cycle, compare in the cycle after the read
  logic [dtbl_pkg::TableEntries-1:0] valid_q;
  logic [dtbl_pkg::IdxW-1:0] sc_q, cmp_idx_q, hit_idx_q, free_idx_q, slot_q;
  logic scan_q, cmp_vld_q, hit_f_q, free_f_q;
  logic [dtbl_pkg::KeyW-1:0] key_mem [dtbl_pkg::TableEntries];
  logic [dtbl_pkg::KeyW-1:0] key_rd_q;
  logic cmp_ok;

  assign cmp_ok = cmp_vld_q && valid_q[cmp_idx_q] && (key_rd_q == key_cur);

  always_ff @(posedge clk_i) begin
    key_rd_q <= key_mem[sc_q];
    if (cmd_i.alloc) key_mem[free_idx_q] <= key_cur;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      sc_q      <= '0;
      scan_q    <= 1'b0;
      cmp_vld_q <= 1'b0;
      cmp_idx_q <= '0;
      hit_f_q   <= 1'b0;
      free_f_q  <= 1'b0;
    end else begin
      cmp_vld_q <= scan_q;
      cmp_idx_q <= sc_q;
      if (cmd_i.scan_start) begin
        sc_q     <= '0;
        scan_q   <= 1'b1;
        hit_f_q  <= 1'b0;
        free_f_q <= 1'b0;
      end else begin
        if (scan_q) begin
          sc_q <= sc_q + 1'b1;
          if (sc_q == LastIdx) scan_q <= 1'b0;
        end
        if (cmp_ok && !hit_f_q) hit_f_q <= 1'b1;
        if (cmp_vld_q && !valid_q[cmp_idx_q] && !free_f_q) free_f_q <= 1'b1;
      end
      if (cmd_i.alloc) valid_q[free_idx_q] <= 1'b1;
      if (cmd_i.rm_clear && hit_f_q) valid_q[hit_idx_q] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmp_ok && !hit_f_q) hit_idx_q <= cmp_idx_q;
    if (cmp_vld_q && !valid_q[cmp_idx_q] && !free_f_q) free_idx_q <= cmp_idx_q;
    if (cmd_i.take_hit) slot_q <= hit_idx_q;
    else if (cmd_i.alloc) slot_q <= free_idx_q;
  end

  // bucket state
  logic [dtbl_pkg::TokW-1:0]  tok_mem  [dtbl_pkg::TableEntries];
  logic [dtbl_pkg::TickW-1:0] tick_mem [dtbl_pkg::TableEntries];
  logic [dtbl_pkg::TokW-1:0]  tok_rd_q, tok_c_q;
  logic [dtbl_pkg::TickW-1:0] tick_rd_q, tick_c_q;
  logic [dtbl_pkg::TickW-1:0] diff;
  logic [dtbl_pkg::ElW-1:0]   el_q;
  logic                       adv_q;
  logic [dtbl_pkg::ProdW-1:0] plo_q, phi_q;
  logic [dtbl_pkg::SumW-1:0]  sum_q;
  logic [dtbl_pkg::TokW-1:0]  tok_ref, tok_new;
  logic                       grant, grant_q;

  assign diff = req_q.now_ticks - tick_c_q;

  always_comb begin
    if (!adv_q) tok_ref = tok_c_q;
    else if (tok_c_q >= cap || sum_q >= dtbl_pkg::SumW'(cap)) tok_ref = cap;
    else tok_ref = sum_q[dtbl_pkg::TokW-1:0];
    grant   = (tok_ref >= OneTok);
    tok_new = grant ? tok_ref - OneTok : tok_ref;
  end

  always_ff @(posedge clk_i) begin
    tok_rd_q  <= tok_mem[slot_q];
    tick_rd_q <= tick_mem[slot_q];
    if (cmd_i.alloc) begin
      tok_c_q  <= cap;
      tick_c_q <= req_q.now_ticks;
    end else if (cmd_i.ld_cur) begin
      tok_c_q  <= tok_rd_q;
      tick_c_q <= tick_rd_q;
    end
    if (cmd_i.el_en) begin
      adv_q <= req_q.now_ticks > tick_c_q;
      if (req_q.now_ticks <= tick_c_q) el_q <= '0;
      else if (diff > dtbl_pkg::TickW'(dtbl_pkg::ElMax)) el_q <= dtbl_pkg::ElMax;
      else el_q <= diff[dtbl_pkg::ElW-1:0];
    end
    if (cmd_i.mul_en) begin
      plo_q <= el_q[dtbl_pkg::ElHalfW-1:0] * rate;
      phi_q <= el_q[dtbl_pkg::ElW-1:dtbl_pkg::ElHalfW] * rate;
    end
    if (cmd_i.add_en) begin
      sum_q <= dtbl_pkg::SumW'(tok_c_q) + dtbl_pkg::SumW'(plo_q)
             + (dtbl_pkg::SumW'(phi_q) << dtbl_pkg::ElHalfW);
    end
    if (cmd_i.upd_en) begin
      tok_mem[slot_q]  <= tok_new;
      tick_mem[slot_q] <= adv_q ? req_q.now_ticks : tick_c_q;
      grant_q <= grant;
    end
  end

  assign sts_o.scan_done = cmp_vld_q && (cmp_idx_q == LastIdx);
  assign sts_o.hit       = hit_f_q;
  assign sts_o.has_free  = free_f_q;
  assign sts_o.grant     = grant_q;

endmodule
`default_nettype wire

// File: rtl/dual_token_bucket_limiter.sv
// One word in flight: a remove, a check that the address bucket ends and a check
//   that reaches the session bucket each finish before the next word is taken.
// The next word is taken in the cycle after the result word loads. Each lookup
//   scans the 64-entry key memory one entry per cycle, then decides in StLook;
//   checks refill and update in StRd to StChk on a hit, StEl to StChk on a new entry.
// Reset: asynchronous, active low; clears all entry valid bits, config, FSM.
`default_nettype none
module dual_token_bucket_limiter (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire dtbl_pkg::req_t                in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output dtbl_pkg::rsp_t                     out_data_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [dtbl_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [dtbl_pkg::CfgDataW-1:0] cfg_data_i
);

  dtbl_pkg::cmd_t cmd;
  dtbl_pkg::sts_t sts;

  // config writes are always taken
  assign cfg_ready_o = 1'b1;

  // sequencer: remove, or address then session bucket on a grant; result word
  dtbl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (in_data_i.req_type),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // table, key scan and refill arithmetic
  dtbl_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
`default_nettype wire

// File: rtl/dtbl_checker.sv
`default_nettype none
module dtbl_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_ready_o,
  input wire logic           out_valid_o,
  input wire logic           out_ready_i,
  input wire dtbl_pkg::rsp_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result word changed while stalled");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a word is in work");

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.allowed && out_data_o.table_full))
    else $error("grant together with table full");

endmodule

bind dual_token_bucket_limiter dtbl_checker u_dtbl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire
